FILE: hw/rtl/dual_countdown_clock_with_increment_defines.svh
// Assertion macros used by the clock's top module.
`ifndef DUAL_COUNTDOWN_CLOCK_WITH_INCREMENT_DEFINES_SVH
`define DUAL_COUNTDOWN_CLOCK_WITH_INCREMENT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define DCCWI_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dccwi assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define DCCWI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dccwi assertion failed");

`endif

FILE: hw/rtl/dccwi_pkg.sv
package dccwi_pkg;

  localparam int MinW  = 8;
  localparam int SecW  = 6;
  localparam int TickW = 8;
  localparam int IncW  = 8;
  localparam int CfgW  = 8;
  localparam int CfgIdxW = 3;

  localparam logic [SecW-1:0] SecMax = SecW'(59);
  localparam logic [MinW-1:0] MinMax = MinW'(255);

  localparam logic SideWhite = 1'b0;
  localparam logic SideBlack = 1'b1;

  localparam logic [1:0] FlagNone  = 2'd0;
  localparam logic [1:0] FlagWhite = 2'd1;
  localparam logic [1:0] FlagBlack = 2'd2;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdStart  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WHITE_MIN = 3'd0,
    CFG_WHITE_SEC = 3'd1,
    CFG_BLACK_MIN = 3'd2,
    CFG_BLACK_SEC = 3'd3,
    CFG_INC_SEC   = 3'd4,
    CFG_TICKS     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic command;
    logic white_button;
    logic black_button;
    logic pause_button;
  } in_t;

  typedef struct packed {
    logic [MinW-1:0] white_minutes_left;
    logic [SecW-1:0] white_seconds_left;
    logic [MinW-1:0] black_minutes_left;
    logic [SecW-1:0] black_seconds_left;
    logic            running_side;
    logic            is_paused;
    logic [1:0]      flag_state;
  } out_t;

  // Time of one side.
  typedef struct packed {
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [TickW-1:0] prescaler;
  } side_t;

  // Work requested of one side for the current sample.
  typedef struct packed {
    logic do_inc;
    logic do_tick;
  } side_ctl_t;

  function automatic logic [SecW-1:0] clamp_sec(input logic [SecW-1:0] s);
    return (s > SecMax) ? SecMax : s;
  endfunction

endpackage

FILE: hw/rtl/dccwi_side.sv
module dccwi_side
  import dccwi_pkg::*;
(
  input  side_t            side_i,
  input  side_ctl_t        ctl_i,
  input  logic [IncW-1:0]  inc_sec_i,
  input  logic [TickW-1:0] tps_i,
  output side_t            side_o,
  output logic             flag_o
);

  localparam int TotW = IncW + 1;

  logic [TotW-1:0]  total;
  logic [2:0]       carry_min;
  logic [TotW-1:0]  carry_sub;
  logic [MinW:0]    inc_min;
  logic [TickW:0]   pre_next;
  logic [TickW-1:0] tps_eff;
  logic             expire;

  // Split seconds plus increment into minutes carried and seconds left
  always_comb begin
    total = TotW'(side_i.seconds) + TotW'(inc_sec_i);
    if (total >= TotW'(300)) begin
      carry_min = 3'd5;
      carry_sub = TotW'(300);
    end else if (total >= TotW'(240)) begin
      carry_min = 3'd4;
      carry_sub = TotW'(240);
    end else if (total >= TotW'(180)) begin
      carry_min = 3'd3;
      carry_sub = TotW'(180);
    end else if (total >= TotW'(120)) begin
      carry_min = 3'd2;
      carry_sub = TotW'(120);
    end else if (total >= TotW'(60)) begin
      carry_min = 3'd1;
      carry_sub = TotW'(60);
    end else begin
      carry_min = 3'd0;
      carry_sub = '0;
    end
    inc_min = (MinW+1)'(side_i.minutes) + (MinW+1)'(carry_min);
  end

  // Advance the prescaler; a zero rate counts as one
  always_comb begin
    tps_eff  = (tps_i == '0) ? TickW'(1) : tps_i;
    pre_next = (TickW+1)'(side_i.prescaler) + (TickW+1)'(1);
    expire   = pre_next >= (TickW+1)'(tps_eff);
  end

  // Apply increment or tick to this side's time
  always_comb begin
    side_o = side_i;
    flag_o = 1'b0;
    if (ctl_i.do_inc) begin
      if (inc_min > (MinW+1)'(MinMax)) begin
        side_o.minutes = MinMax;
        side_o.seconds = SecMax;
      end else begin
        side_o.minutes = inc_min[MinW-1:0];
        side_o.seconds = SecW'(total - carry_sub);
      end
    end else if (ctl_i.do_tick) begin
      if (expire) begin
        side_o.prescaler = '0;
        if (side_i.seconds != '0) begin
          side_o.seconds = side_i.seconds - SecW'(1);
          flag_o = (side_i.minutes == '0) && (side_i.seconds == SecW'(1));
        end else if (side_i.minutes != '0) begin
          side_o.minutes = side_i.minutes - MinW'(1);
          side_o.seconds = SecMax;
        end else begin
          flag_o = 1'b1;
        end
      end else begin
        side_o.prescaler = pre_next[TickW-1:0];
      end
    end
  end

endmodule

FILE: hw/rtl/dccwi_out_buf.sv
module dccwi_out_buf
  import dccwi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic ready_i,
  output out_t data_o
);

  out_t main_q, main_d, skid_q, skid_d;
  logic main_valid_q, main_valid_d, skid_valid_q, skid_valid_d;
  logic pop;

  assign pop     = main_valid_q && ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  // Refill the head from the skid slot first, keep order
  always_comb begin
    main_d       = main_q;
    main_valid_d = main_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (pop || !main_valid_q) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

FILE: hw/rtl/dual_countdown_clock_with_increment.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | in_data_i  (in_t)
// out     | output    | out_valid_o / out_ready_i  | out_data_o (out_t)
// cfg     | input     | cfg_we_i, no wait          | cfg_idx_i, cfg_data_i
//
// One item per cycle while the output buffer has room: a sample updates the clock
// state and its result is registered into the output buffer at the same edge.
// A two-entry output buffer takes a new transfer while one result waits.
// Input stalls only when both output entries are full.
// Reset clears state and configuration; ticks_per_second resets to 10.
module dual_countdown_clock_with_increment
  import dccwi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

`include "dual_countdown_clock_with_increment_defines.svh"

  logic [MinW-1:0]  wstart_min_q, bstart_min_q;
  logic [SecW-1:0]  wstart_sec_q, bstart_sec_q;
  logic [IncW-1:0]  inc_sec_q;
  logic [TickW-1:0] tps_q;

  side_t      white_q, white_d, black_q, black_d, white_upd, black_upd;
  side_ctl_t  white_ctl, black_ctl;
  logic       white_flag, black_flag;
  logic       active_q, active_d, running_q, running_d;
  logic       paused_q, paused_d, last_pause_q;
  logic [1:0] flag_q, flag_d;
  logic       push, press, pause_edge, presser, tick, press_ok, paused_mid;
  logic [SecW-1:0] wload_sec;
  out_t       result;

  assign push = in_valid_i && in_ready_o;

  // Hold configuration written by the register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wstart_min_q <= '0;
      wstart_sec_q <= '0;
      bstart_min_q <= '0;
      bstart_sec_q <= '0;
      inc_sec_q    <= '0;
      tps_q        <= TickW'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WHITE_MIN: wstart_min_q <= cfg_data_i[MinW-1:0];
        CFG_WHITE_SEC: wstart_sec_q <= cfg_data_i[SecW-1:0];
        CFG_BLACK_MIN: bstart_min_q <= cfg_data_i[MinW-1:0];
        CFG_BLACK_SEC: bstart_sec_q <= cfg_data_i[SecW-1:0];
        CFG_INC_SEC:   inc_sec_q    <= cfg_data_i[IncW-1:0];
        CFG_TICKS:     tps_q        <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Decode buttons: white over black over pause
  always_comb begin
    press      = in_data_i.white_button || in_data_i.black_button;
    presser    = in_data_i.white_button ? SideWhite : SideBlack;
    pause_edge = in_data_i.pause_button && !last_pause_q;
    press_ok   = press && !paused_q && (presser == active_q);
    paused_mid = (!press && pause_edge) ? !paused_q : paused_q;
    active_d   = press_ok ? !active_q : active_q;
    tick       = !paused_mid;
    white_ctl.do_inc  = press_ok && (presser == SideWhite);
    black_ctl.do_inc  = press_ok && (presser == SideBlack);
    white_ctl.do_tick = tick && (active_d == SideWhite);
    black_ctl.do_tick = tick && (active_d == SideBlack);
  end

  dccwi_side u_white (
    .side_i    (white_q),
    .ctl_i     (white_ctl),
    .inc_sec_i (inc_sec_q),
    .tps_i     (tps_q),
    .side_o    (white_upd),
    .flag_o    (white_flag)
  );

  dccwi_side u_black (
    .side_i    (black_q),
    .ctl_i     (black_ctl),
    .inc_sec_i (inc_sec_q),
    .tps_i     (tps_q),
    .side_o    (black_upd),
    .flag_o    (black_flag)
  );

  // Select the next game state: start, running sample, or hold
  always_comb begin
    white_d   = white_q;
    black_d   = black_q;
    running_d = running_q;
    paused_d  = paused_q;
    flag_d    = flag_q;
    wload_sec = clamp_sec(wstart_sec_q);
    if (in_data_i.command == CmdStart) begin
      white_d.minutes   = wstart_min_q;
      white_d.seconds   = wload_sec;
      white_d.prescaler = '0;
      if (bstart_min_q == '0 && bstart_sec_q == '0) begin
        black_d.minutes = wstart_min_q;
        black_d.seconds = wload_sec;
      end else begin
        black_d.minutes = bstart_min_q;
        black_d.seconds = clamp_sec(bstart_sec_q);
      end
      black_d.prescaler = '0;
      running_d = 1'b1;
      paused_d  = 1'b0;
      flag_d    = FlagNone;
    end else if (running_q) begin
      white_d  = white_upd;
      black_d  = black_upd;
      paused_d = paused_mid;
      if (white_flag || black_flag) begin
        running_d = 1'b0;
        flag_d    = (active_d == SideWhite) ? FlagWhite : FlagBlack;
      end
    end
  end

  // Advance state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q      <= '0;
      black_q      <= '0;
      active_q     <= SideWhite;
      running_q    <= 1'b0;
      paused_q     <= 1'b0;
      flag_q       <= FlagNone;
      last_pause_q <= 1'b0;
    end else if (push) begin
      white_q      <= white_d;
      black_q      <= black_d;
      active_q     <= (in_data_i.command == CmdStart) ? SideWhite :
                      (running_q ? active_d : active_q);
      running_q    <= running_d;
      paused_q     <= paused_d;
      flag_q       <= flag_d;
      last_pause_q <= in_data_i.pause_button;
    end
  end

  // Form the result from the updated state
  always_comb begin
    result.white_minutes_left = white_d.minutes;
    result.white_seconds_left = white_d.seconds;
    result.black_minutes_left = black_d.minutes;
    result.black_seconds_left = black_d.seconds;
    result.running_side       = (in_data_i.command == CmdStart) ? SideWhite :
                                (running_q ? active_d : active_q);
    result.is_paused          = paused_d;
    result.flag_state         = flag_d;
  end

  dccwi_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  `DCCWI_ASSERT(a_flag_stops, clk_i, rst_ni, (flag_q == FlagNone) || !running_q)
  `DCCWI_ASSERT(a_pause_needs_run, clk_i, rst_ni, !paused_q || running_q)
  `DCCWI_ASSERT(a_sec_range, clk_i, rst_ni, (white_q.seconds <= SecMax) && (black_q.seconds <= SecMax))
  `DCCWI_ASSERT(a_empty_ready, clk_i, rst_ni, out_valid_o || in_ready_o)
  `DCCWI_ASSERT_NEXT(a_push_shows, clk_i, rst_ni, push, out_valid_o)

endmodule

FILE: sim/dccwi_clock_checker.sv
module dccwi_clock_checker
  import dccwi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_t                in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_t               out_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TicksAtReset = 10;

  // Shadow copy of the configuration registers; start times indexed by side
  logic [MinW-1:0]  start_min [2];
  logic [SecW-1:0]  start_sec [2];
  logic [IncW-1:0]  inc_sec;
  logic [TickW-1:0] tick_div;

  // Shadow copy of the clock state
  side_t       side_time [2];
  logic        active;
  logic        running;
  logic        paused;
  logic        last_pause;
  logic [1:0]  flag;

  // Displays still owed by the block, oldest first
  out_t shown_time_q [$];
  int   mismatches;

  // Apply one sample or start command and return the display that follows it
  task automatic advance_clock(input in_t s, output out_t r);
    int         who;
    int         total;
    int         mins;
    int         tps;
    logic [8:0] nxt;
    logic       rise;
    logic       out_of_time;
    rise = s.pause_button && !last_pause;
    if (s.command == CmdStart) begin
      side_time[SideWhite].minutes = start_min[SideWhite];
      side_time[SideWhite].seconds =
          (start_sec[SideWhite] > SecMax) ? SecMax : start_sec[SideWhite];
      // black takes white's loaded time when its own start time is 0:00
      if (start_min[SideBlack] == '0 && start_sec[SideBlack] == '0) begin
        side_time[SideBlack].minutes = side_time[SideWhite].minutes;
        side_time[SideBlack].seconds = side_time[SideWhite].seconds;
      end else begin
        side_time[SideBlack].minutes = start_min[SideBlack];
        side_time[SideBlack].seconds =
            (start_sec[SideBlack] > SecMax) ? SecMax : start_sec[SideBlack];
      end
      side_time[SideWhite].prescaler = '0;
      side_time[SideBlack].prescaler = '0;
      active  = SideWhite;
      running = 1'b1;
      paused  = 1'b0;
      flag    = FlagNone;
    end else if (running) begin
      if (s.white_button || s.black_button) begin
        // white wins over black; only the running side's press counts, and not while paused
        who = s.white_button ? int'(SideWhite) : int'(SideBlack);
        if (!paused && who == int'(active)) begin
          total = side_time[who].seconds + inc_sec;
          mins  = side_time[who].minutes + total / 60;
          if (mins > MinMax) begin
            side_time[who].minutes = MinMax;
            side_time[who].seconds = SecMax;
          end else begin
            side_time[who].minutes = MinW'(mins);
            side_time[who].seconds = SecW'(total % 60);
          end
          active = ~active;
        end
      end else if (rise) begin
        paused = ~paused;
      end
      // advance the running side's prescaler, take a second when it wraps
      if (!paused) begin
        tps = (tick_div == '0) ? 1 : int'(tick_div);
        nxt = side_time[active].prescaler + 9'd1;
        if (nxt >= tps) begin
          side_time[active].prescaler = '0;
          out_of_time = 1'b0;
          if (side_time[active].seconds != '0) begin
            side_time[active].seconds = side_time[active].seconds - 1'b1;
          end else if (side_time[active].minutes != '0) begin
            side_time[active].minutes = side_time[active].minutes - 1'b1;
            side_time[active].seconds = SecMax;
          end else begin
            out_of_time = 1'b1;
          end
          if (side_time[active].minutes == '0 && side_time[active].seconds == '0) begin
            out_of_time = 1'b1;
          end
          if (out_of_time) begin
            flag    = (active == SideWhite) ? FlagWhite : FlagBlack;
            running = 1'b0;
          end
        end else begin
          side_time[active].prescaler = nxt[TickW-1:0];
        end
      end
    end
    last_pause = s.pause_button;

    r.white_minutes_left = side_time[SideWhite].minutes;
    r.white_seconds_left = side_time[SideWhite].seconds;
    r.black_minutes_left = side_time[SideBlack].minutes;
    r.black_seconds_left = side_time[SideBlack].seconds;
    r.running_side       = active;
    r.is_paused          = paused;
    r.flag_state         = flag;
  endtask

  function automatic int field_off(string field, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    return 1;
  endfunction

  // Track config writes, check each output transfer, predict each input transfer
  always @(posedge clk_i or negedge rst_ni) begin : track_p
    out_t want;
    out_t res;
    if (!rst_ni) begin
      start_min[SideWhite] = '0;
      start_min[SideBlack] = '0;
      start_sec[SideWhite] = '0;
      start_sec[SideBlack] = '0;
      inc_sec    = '0;
      tick_div   = TickW'(TicksAtReset);
      side_time[SideWhite] = '0;
      side_time[SideBlack] = '0;
      active     = SideWhite;
      running    = 1'b0;
      paused     = 1'b0;
      last_pause = 1'b0;
      flag       = FlagNone;
      mismatches = 0;
      shown_time_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WHITE_MIN: start_min[SideWhite] = cfg_data_i[MinW-1:0];
          CFG_WHITE_SEC: start_sec[SideWhite] = cfg_data_i[SecW-1:0];
          CFG_BLACK_MIN: start_min[SideBlack] = cfg_data_i[MinW-1:0];
          CFG_BLACK_SEC: start_sec[SideBlack] = cfg_data_i[SecW-1:0];
          CFG_INC_SEC:   inc_sec  = cfg_data_i[IncW-1:0];
          CFG_TICKS:     tick_div = cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (shown_time_q.size() == 0) begin
          $display("%0t: display transfer with nothing owed, got %h", $time, out_data_i);
          mismatches++;
        end else begin
          want = shown_time_q.pop_front();
          mismatches += field_off("white minutes", want.white_minutes_left,
                                  out_data_i.white_minutes_left);
          mismatches += field_off("white seconds", want.white_seconds_left,
                                  out_data_i.white_seconds_left);
          mismatches += field_off("black minutes", want.black_minutes_left,
                                  out_data_i.black_minutes_left);
          mismatches += field_off("black seconds", want.black_seconds_left,
                                  out_data_i.black_seconds_left);
          mismatches += field_off("running side", want.running_side,
                                  out_data_i.running_side);
          mismatches += field_off("paused", want.is_paused, out_data_i.is_paused);
          mismatches += field_off("flag", want.flag_state, out_data_i.flag_state);
        end
      end

      if (in_valid_i && in_ready_i) begin
        advance_clock(in_data_i, res);
        shown_time_q.push_back(res);
      end

      pending_o    <= shown_time_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: sim/tb_dual_countdown_clock_with_increment.sv
module tb_dual_countdown_clock_with_increment
  import dccwi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 60;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 116;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_t               out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  dual_countdown_clock_with_increment i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  dccwi_clock_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Display side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      if (hold_req) begin
        repeat (HoldCycles) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk_i);
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_t pack_sample(logic cmd, logic wb, logic bb, logic pb);
    in_t s;
    s.command      = cmd;
    s.white_button = wb;
    s.black_button = bb;
    s.pause_button = pb;
    return s;
  endfunction

  // Mostly button samples; a start now and then so that games restart after a flag
  function automatic in_t random_sample();
    return pack_sample(($urandom_range(99) < 6) ? CmdStart : CmdSample,
                       $urandom_range(99) < 25, $urandom_range(99) < 25,
                       $urandom_range(99) < 12);
  endfunction

  // Offer one sample, with random gaps ahead of it, and hold it until transfer
  task automatic send_item(input in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every owed display has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic program_clock(input logic [7:0] wmin, input logic [7:0] wsec,
                               input logic [7:0] bmin, input logic [7:0] bsec,
                               input logic [7:0] inc, input logic [7:0] ticks);
    cfg_reg_e    idx   [6];
    logic [7:0]  value [6];
    idx   = '{CFG_WHITE_MIN, CFG_WHITE_SEC, CFG_BLACK_MIN, CFG_BLACK_SEC,
              CFG_INC_SEC, CFG_TICKS};
    value = '{wmin, wsec, bmin, bsec, inc, ticks};
    for (int k = 0; k < 6; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= value[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] wmin, wsec, bmin, bsec, inc, ticks;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_WHITE_MIN;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No game yet: samples leave the display at zero
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b1));
    send_item(pack_sample(CmdSample, 1'b1, 1'b1, 1'b0));

    // Top of range: seconds above 59 load as 59, black copies white, tick divider zero
    wait_drained();
    program_clock(8'd255, 8'd63, 8'd0, 8'd0, 8'd255, 8'd0);
    send_item(pack_sample(CmdStart,  1'b0, 1'b0, 1'b1));
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b1));
    send_item(pack_sample(CmdSample, 1'b1, 1'b0, 1'b0));
    send_item(pack_sample(CmdSample, 1'b1, 1'b0, 1'b0));
    send_item(pack_sample(CmdSample, 1'b0, 1'b1, 1'b1));
    send_item(pack_sample(CmdSample, 1'b1, 1'b1, 1'b1));
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b0));
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b1));
    send_item(pack_sample(CmdSample, 1'b0, 1'b1, 1'b0));
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b0));
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b1));
    send_item(pack_sample(CmdStart,  1'b1, 1'b1, 1'b0));

    // Both sides at 0:00: the first tick drops white's flag, then nothing moves
    wait_drained();
    program_clock(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
    send_item(pack_sample(CmdStart,  1'b0, 1'b0, 1'b0));
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b0));
    send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b1));
    send_item(pack_sample(CmdSample, 1'b1, 1'b0, 1'b0));

    // Shrink the tick divider under a prescaler that has already counted up
    wait_drained();
    program_clock(8'd0, 8'd5, 8'd0, 8'd7, 8'd0, 8'd8);
    send_item(pack_sample(CmdStart, 1'b0, 1'b0, 1'b0));
    repeat (6) send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b0));
    wait_drained();
    program_clock(8'd0, 8'd5, 8'd0, 8'd7, 8'd0, 8'd2);
    repeat (2) send_item(pack_sample(CmdSample, 1'b0, 1'b0, 1'b0));

    // Random games over several settings and idling patterns
    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 2) begin
        program_clock(8'd255, 8'd59, 8'd255, 8'd59, 8'd255, 8'd255);
      end else if (ph == 5) begin
        program_clock(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
      end else begin
        wmin  = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'd0;
        wsec  = 8'($urandom_range(12));
        bmin  = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'd0;
        bsec  = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(12, 1));
        inc   = ($urandom_range(5) == 0) ? 8'($urandom_range(255, 60))
                                         : 8'($urandom_range(3));
        ticks = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 4))
                                         : 8'($urandom_range(3, 1));
        program_clock(wmin, wsec, bmin, bsec, inc, ticks);
      end
      if ($urandom_range(1) == 1) send_item(pack_sample(CmdStart, 1'b0, 1'b0, 1'b0));
      for (int n = 0; n < PhaseItems; n++) begin
        // hold the display side off while samples keep coming
        if (ph == 0 && n == PhaseItems / 2) hold_req = 1'b1;
        send_item(random_sample());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: dual_countdown_clock_with_increment.f
+incdir+hw/rtl
hw/rtl/dccwi_pkg.sv
hw/rtl/dccwi_side.sv
hw/rtl/dccwi_out_buf.sv
hw/rtl/dual_countdown_clock_with_increment.sv
sim/dccwi_clock_checker.sv
sim/tb_dual_countdown_clock_with_increment.sv
